// ===== rtl/sbpm_pkg.sv =====
// Shared types and constants of the spherical bulge pixel mapper.
package sbpm_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WARP_ENABLE = 3'd0;
    localparam logic [2:0] CFG_VIEW_PLANE_K = 3'd1;
    localparam logic [2:0] CFG_EYE_HEIGHT_Z = 3'd2;
    localparam logic [2:0] CFG_CANVAS_COLS = 3'd3;
    localparam logic [2:0] CFG_CANVAS_ROWS = 3'd4;
    localparam logic [2:0] CFG_BASELINE_Y = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Square root: 40-bit radicand, 20 result bits, one bit per stage.
    localparam int SQ_STEPS = 20;
    localparam int RAD_W = 40;

    // Divider: saturation check, then 14 quotient bits, one bit per stage.
    localparam int DV_STEPS = 14;
    localparam int DV_W = 40;
    localparam int DEN_W = 26;

    // Per-pixel payload that travels along the whole pipeline.
    typedef struct packed {
        logic [7:0]         col;
        logic [7:0]         row;
        logic [8:0]         gw;
        logic [8:0]         gh;
        logic [8:0]         m;
        logic signed [8:0]  bl;
        logic signed [8:0]  bt;
        logic [11:0]        pen;
        logic               pix;
        logic signed [10:0] ex;
        logic signed [10:0] ey;
    } item_t;

    // Control flags of the divider stages.
    typedef struct packed {
        logic ok;
        logic negx;
        logic negy;
        logic satx;
        logic saty;
    } div_flags_t;

endpackage

// ===== rtl/spherical_bulge_pixel_mapper.sv =====
// Top level of the spherical bulge pixel mapper: a fully pipelined pixel warp.
//
// One transfer on the input channel (in_valid high, in_stall low) carries one
// glyph pixel; exactly one transfer on the output channel carries its canvas
// position and value, in the same order. The pipeline takes a new pixel every
// cycle unless it is stalled. Its stages run in this order: input register,
// squaring, radicand, 20 square root stages (one root bit each), projection
// factors, products, numerator, divider saturation check, 14 divider stages
// (one quotient bit each) and the clamping output register. All stages move
// together: when out_valid is high and out_stall is high the whole pipeline
// holds and in_stall is raised, so nothing is lost or repeated.
// Reset clears every valid bit and loads the registers with their defaults
// (warp off, k = 0, z = 2.0, canvas 4096 x 1024, baseline 0); no result is
// pending after reset. Configuration writes through cfg_write take effect at
// once and are meant to happen while the pipeline is empty.
module spherical_bulge_pixel_mapper #(
    parameter int MAX_GLYPH = 256,
    parameter int CANVAS_COLS_MAX = 4096,
    parameter int CANVAS_ROWS_MAX = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sbpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbpm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          src_col,
    input  logic [7:0]                          src_row,
    input  logic [8:0]                          glyph_width,
    input  logic [8:0]                          glyph_height,
    input  logic signed [8:0]                   bearing_left,
    input  logic signed [8:0]                   bearing_top,
    input  logic [11:0]                         pen_x,
    input  logic                                pixel_on,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [11:0]                         dest_x,
    output logic [9:0]                          dest_y,
    output logic                                dest_pixel
);

    localparam int SQ = sbpm_pkg::SQ_STEPS;
    localparam int DV = sbpm_pkg::DV_STEPS;
    localparam int RW = sbpm_pkg::RAD_W;
    localparam int DW = sbpm_pkg::DV_W;
    localparam int NW = sbpm_pkg::DEN_W;

    // Caps that fit the fixed field widths.
    localparam int GLYPH_CAP = (MAX_GLYPH > 511) ? 511 : MAX_GLYPH;
    localparam int COLS_CAP = (CANVAS_COLS_MAX > 8191) ? 8191 : CANVAS_COLS_MAX;
    localparam int ROWS_CAP = (CANVAS_ROWS_MAX > 2047) ? 2047 : CANVAS_ROWS_MAX;
    localparam logic [8:0] GLYPH_CAP_V = 9'(GLYPH_CAP);
    localparam logic [12:0] COLS_CAP_V = 13'(COLS_CAP);
    localparam logic [10:0] ROWS_CAP_V = 11'(ROWS_CAP);

    // Configuration registers.
    logic               warp_enable_reg;
    logic signed [15:0] view_plane_k_reg;
    logic [14:0]        eye_height_z_reg;
    logic [12:0]        canvas_cols_reg;
    logic [10:0]        canvas_rows_reg;
    logic [9:0]         baseline_y_reg;

    logic adv;

    // Stage 0: input register.
    sbpm_pkg::item_t    s0_item_reg, s0_item_next;
    logic               s0_vld_reg;
    logic [8:0]         gw_c, gh_c;

    // Stage 1: squares.
    sbpm_pkg::item_t    s1_item_reg;
    logic               s1_vld_reg;
    logic [17:0]        s1_mm_reg, s1_exx_reg, s1_eyy_reg;
    logic [17:0]        s1_mm_next, s1_exx_next, s1_eyy_next;
    logic signed [21:0] exx_full, eyy_full;

    // Square root stages.
    sbpm_pkg::item_t    sq_item_reg [SQ+1];
    logic               sq_vld_reg [SQ+1];
    logic [RW-1:0]      sq_rem_reg [SQ+1];
    logic [RW-1:0]      sq_rem_next [SQ+1];
    logic [SQ-1:0]      sq_root_reg [SQ+1];
    logic [SQ-1:0]      sq_root_next [SQ+1];
    logic [RW:0]        sq_trial [SQ];
    logic signed [20:0] rad_s;
    logic [17:0]        rad_v;

    // Projection factors.
    sbpm_pkg::item_t    p_item_reg;
    logic               p_vld_reg;
    logic signed [NW-1:0] p_dn_reg, p_dn_next;
    logic signed [17:0] p_zk_reg, p_zk_next;
    logic signed [20:0] p_emx_reg, p_emy_reg, p_emx_next, p_emy_next;
    logic [23:0]        mz;

    // Products.
    sbpm_pkg::item_t    q_item_reg;
    logic               q_vld_reg;
    logic signed [NW-1:0] q_dn_reg;
    logic signed [35:0] q_wax_reg, q_way_reg, q_wax_next, q_way_next;
    logic signed [38:0] q_wbx_reg, q_wby_reg, q_wbx_next, q_wby_next;

    // Numerator and denominator.
    sbpm_pkg::item_t    r_item_reg;
    logic               r_vld_reg;
    logic [DW-1:0]      r_nx_reg, r_ny_reg, r_nx_next, r_ny_next;
    logic [NW-1:0]      r_d_reg, r_d_next;
    logic               r_ok_reg, r_negx_reg, r_negy_reg;
    logic               r_ok_next;
    logic signed [39:0] wx, wy, awx, awy;

    // Divider stages.
    sbpm_pkg::item_t    dv_item_reg [DV+1];
    logic               dv_vld_reg [DV+1];
    sbpm_pkg::div_flags_t dv_flags_reg [DV+1];
    sbpm_pkg::div_flags_t dv_flags_next;
    logic [NW-1:0]      dv_d_reg [DV+1];
    logic [DW-1:0]      dv_rx_reg [DV+1], dv_ry_reg [DV+1];
    logic [DW-1:0]      dv_rx_next [DV+1], dv_ry_next [DV+1];
    logic [DV-1:0]      dv_qx_reg [DV+1], dv_qy_reg [DV+1];
    logic [DV-1:0]      dv_qx_next [DV+1], dv_qy_next [DV+1];
    logic [DW-1:0]      dv_dsh [DV];
    logic [DW-1:0]      sat_lim;

    // Output register.
    logic               out_vld_reg;
    logic [11:0]        dest_x_reg, dest_x_next;
    logic [9:0]         dest_y_reg, dest_y_next;
    logic               dest_pixel_reg;
    logic [DV:0]        qx_f, qy_f;
    logic signed [16:0] px, py;
    logic signed [18:0] sx, sy;
    logic [12:0]        lim_x, lim_y;
    logic [12:0]        cl_x, cl_y;
    sbpm_pkg::item_t    fin_item;
    sbpm_pkg::div_flags_t fin_flags;

    function automatic logic [12:0] clamp_pos(input logic signed [18:0] v,
                                              input logic [12:0] lim);
        logic [12:0] res;
        if (v < 0)
        begin
            res = 13'd0;
        end
        else if (v > $signed({6'd0, lim}))
        begin
            res = lim;
        end
        else
        begin
            res = v[12:0];
        end
        return res;
    endfunction

    // The pipeline moves unless the output register holds an untaken result.
    assign adv = !(out_vld_reg && out_stall);
    assign in_stall = !adv;

    // Stage 0 input conditioning.
    always_comb
    begin
        gw_c = (glyph_width > GLYPH_CAP_V) ? GLYPH_CAP_V : glyph_width;
        gh_c = (glyph_height > GLYPH_CAP_V) ? GLYPH_CAP_V : glyph_height;
        s0_item_next.col = src_col;
        s0_item_next.row = src_row;
        s0_item_next.gw = gw_c;
        s0_item_next.gh = gh_c;
        s0_item_next.m = (gw_c > gh_c) ? gw_c : gh_c;
        s0_item_next.bl = bearing_left;
        s0_item_next.bt = bearing_top;
        s0_item_next.pen = pen_x;
        s0_item_next.pix = pixel_on;
        // Offsets from the glyph centre in half pixels.
        s0_item_next.ex = $signed({2'b00, src_col, 1'b0} - {2'b00, gw_c});
        s0_item_next.ey = $signed({2'b00, src_row, 1'b0} - {2'b00, gh_c});
    end

    // Squares of radius and offsets.
    always_comb
    begin
        s1_mm_next = s0_item_reg.m * s0_item_reg.m;
        exx_full = s0_item_reg.ex * s0_item_reg.ex;
        eyy_full = s0_item_reg.ey * s0_item_reg.ey;
        s1_exx_next = exx_full[17:0];
        s1_eyy_next = eyy_full[17:0];
    end

    // Radicand, clamped at zero for corner pixels, then the root stages.
    always_comb
    begin
        rad_s = $signed({3'b000, s1_mm_reg}) - $signed({3'b000, s1_exx_reg})
              - $signed({3'b000, s1_eyy_reg});
        rad_v = (rad_s > 0) ? rad_s[17:0] : 18'd0;
        sq_rem_next[0] = {rad_v, 22'd0};
        sq_root_next[0] = '0;
        for (int j = 0; j < SQ; j++)
        begin
            sq_trial[j] = ((RW + 1)'(sq_root_reg[j]) << (SQ - j))
                        | ((RW + 1)'(1) << (2 * (SQ - 1 - j)));
            if ({1'b0, sq_rem_reg[j]} >= sq_trial[j])
            begin
                sq_rem_next[j + 1] = sq_rem_reg[j] - sq_trial[j][RW-1:0];
                sq_root_next[j + 1] = sq_root_reg[j] | (SQ'(1) << (SQ - 1 - j));
            end
            else
            begin
                sq_rem_next[j + 1] = sq_rem_reg[j];
                sq_root_next[j + 1] = sq_root_reg[j];
            end
        end
    end

    // Projection factors: dn = m*z - 2*h, zk = z - k, e*m.
    always_comb
    begin
        mz = sq_item_reg[SQ].m * eye_height_z_reg;
        p_dn_next = $signed({2'b00, mz}) - $signed({5'd0, sq_root_reg[SQ], 1'b0});
        p_zk_next = $signed({3'b000, eye_height_z_reg})
                  - $signed({{2{view_plane_k_reg[15]}}, view_plane_k_reg});
        p_emx_next = sq_item_reg[SQ].ex * $signed({1'b0, sq_item_reg[SQ].m});
        p_emy_next = sq_item_reg[SQ].ey * $signed({1'b0, sq_item_reg[SQ].m});
    end

    always_comb
    begin
        q_wax_next = $signed({1'b0, p_item_reg.gw}) * p_dn_reg;
        q_way_next = $signed({1'b0, p_item_reg.gh}) * p_dn_reg;
        q_wbx_next = p_emx_reg * p_zk_reg;
        q_wby_next = p_emy_reg * p_zk_reg;
    end

    // The warped position is W / (2*dn); rounding half away from zero gives
    // floor((|W| + dn) / (2*dn)) with the sign of W.
    always_comb
    begin
        wx = 40'(q_wax_reg) + 40'(q_wbx_reg);
        wy = 40'(q_way_reg) + 40'(q_wby_reg);
        awx = wx[39] ? -wx : wx;
        awy = wy[39] ? -wy : wy;
        r_nx_next = awx + 40'(q_dn_reg);
        r_ny_next = awy + 40'(q_dn_reg);
        r_d_next = {q_dn_reg[NW-2:0], 1'b0};
        r_ok_next = warp_enable_reg && (q_dn_reg > 0);
    end

    // Divider: a quotient of 2^14 or more always clamps, so it saturates there.
    always_comb
    begin
        sat_lim = {r_d_reg, 14'd0};
        dv_flags_next.ok = r_ok_reg;
        dv_flags_next.negx = r_negx_reg;
        dv_flags_next.negy = r_negy_reg;
        dv_flags_next.satx = (r_nx_reg >= sat_lim);
        dv_flags_next.saty = (r_ny_reg >= sat_lim);
        dv_rx_next[0] = r_nx_reg;
        dv_ry_next[0] = r_ny_reg;
        dv_qx_next[0] = '0;
        dv_qy_next[0] = '0;
        for (int j = 0; j < DV; j++)
        begin
            dv_dsh[j] = DW'(dv_d_reg[j]) << (DV - 1 - j);
            if (dv_rx_reg[j] >= dv_dsh[j])
            begin
                dv_rx_next[j + 1] = dv_rx_reg[j] - dv_dsh[j];
                dv_qx_next[j + 1] = dv_qx_reg[j] | (DV'(1) << (DV - 1 - j));
            end
            else
            begin
                dv_rx_next[j + 1] = dv_rx_reg[j];
                dv_qx_next[j + 1] = dv_qx_reg[j];
            end
            if (dv_ry_reg[j] >= dv_dsh[j])
            begin
                dv_ry_next[j + 1] = dv_ry_reg[j] - dv_dsh[j];
                dv_qy_next[j + 1] = dv_qy_reg[j] | (DV'(1) << (DV - 1 - j));
            end
            else
            begin
                dv_ry_next[j + 1] = dv_ry_reg[j];
                dv_qy_next[j + 1] = dv_qy_reg[j];
            end
        end
    end

    // Final placement and clamping to the canvas.
    always_comb
    begin
        fin_item = dv_item_reg[DV];
        fin_flags = dv_flags_reg[DV];
        qx_f = fin_flags.satx ? (DV + 1)'(1 << DV) : {1'b0, dv_qx_reg[DV]};
        qy_f = fin_flags.saty ? (DV + 1)'(1 << DV) : {1'b0, dv_qy_reg[DV]};
        if (fin_flags.ok)
        begin
            px = fin_flags.negx ? -$signed({2'b00, qx_f}) : $signed({2'b00, qx_f});
            py = fin_flags.negy ? -$signed({2'b00, qy_f}) : $signed({2'b00, qy_f});
        end
        else
        begin
            px = $signed({9'd0, fin_item.col});
            py = $signed({9'd0, fin_item.row});
        end
        sx = 19'(px) + 19'(fin_item.bl) + $signed({7'd0, fin_item.pen});
        sy = 19'(py) - 19'(fin_item.bt) + $signed({9'd0, baseline_y_reg});
        if (canvas_cols_reg > COLS_CAP_V)
        begin
            lim_x = COLS_CAP_V - 13'd1;
        end
        else if (canvas_cols_reg == 13'd0)
        begin
            lim_x = 13'd0;
        end
        else
        begin
            lim_x = canvas_cols_reg - 13'd1;
        end
        if (canvas_rows_reg > ROWS_CAP_V)
        begin
            lim_y = {2'b00, ROWS_CAP_V - 11'd1};
        end
        else if (canvas_rows_reg == 11'd0)
        begin
            lim_y = 13'd0;
        end
        else
        begin
            lim_y = {2'b00, canvas_rows_reg - 11'd1};
        end
        cl_x = clamp_pos(sx, lim_x);
        cl_y = clamp_pos(sy, lim_y);
        dest_x_next = cl_x[11:0];
        dest_y_next = cl_y[9:0];
    end

    // Configuration registers and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warp_enable_reg <= 1'b0;
            view_plane_k_reg <= '0;
            eye_height_z_reg <= 15'd8192;
            canvas_cols_reg <= 13'd4096;
            canvas_rows_reg <= 11'd1024;
            baseline_y_reg <= '0;
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            for (int j = 0; j <= SQ; j++)
            begin
                sq_vld_reg[j] <= 1'b0;
            end
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            for (int j = 0; j <= DV; j++)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sbpm_pkg::CFG_WARP_ENABLE: warp_enable_reg <= cfg_data[0];
                    sbpm_pkg::CFG_VIEW_PLANE_K: view_plane_k_reg <= $signed(cfg_data);
                    sbpm_pkg::CFG_EYE_HEIGHT_Z: eye_height_z_reg <= cfg_data[14:0];
                    sbpm_pkg::CFG_CANVAS_COLS: canvas_cols_reg <= cfg_data[12:0];
                    sbpm_pkg::CFG_CANVAS_ROWS: canvas_rows_reg <= cfg_data[10:0];
                    sbpm_pkg::CFG_BASELINE_Y: baseline_y_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (adv)
            begin
                s0_vld_reg <= in_valid;
                s1_vld_reg <= s0_vld_reg;
                sq_vld_reg[0] <= s1_vld_reg;
                for (int j = 0; j < SQ; j++)
                begin
                    sq_vld_reg[j + 1] <= sq_vld_reg[j];
                end
                p_vld_reg <= sq_vld_reg[SQ];
                q_vld_reg <= p_vld_reg;
                r_vld_reg <= q_vld_reg;
                dv_vld_reg[0] <= r_vld_reg;
                for (int j = 0; j < DV; j++)
                begin
                    dv_vld_reg[j + 1] <= dv_vld_reg[j];
                end
                out_vld_reg <= dv_vld_reg[DV];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg <= s0_item_next;
            s1_item_reg <= s0_item_reg;
            s1_mm_reg <= s1_mm_next;
            s1_exx_reg <= s1_exx_next;
            s1_eyy_reg <= s1_eyy_next;
            sq_item_reg[0] <= s1_item_reg;
            sq_rem_reg[0] <= sq_rem_next[0];
            sq_root_reg[0] <= sq_root_next[0];
            for (int j = 0; j < SQ; j++)
            begin
                sq_item_reg[j + 1] <= sq_item_reg[j];
                sq_rem_reg[j + 1] <= sq_rem_next[j + 1];
                sq_root_reg[j + 1] <= sq_root_next[j + 1];
            end
            p_item_reg <= sq_item_reg[SQ];
            p_dn_reg <= p_dn_next;
            p_zk_reg <= p_zk_next;
            p_emx_reg <= p_emx_next;
            p_emy_reg <= p_emy_next;
            q_item_reg <= p_item_reg;
            q_dn_reg <= p_dn_reg;
            q_wax_reg <= q_wax_next;
            q_way_reg <= q_way_next;
            q_wbx_reg <= q_wbx_next;
            q_wby_reg <= q_wby_next;
            r_item_reg <= q_item_reg;
            r_nx_reg <= r_nx_next;
            r_ny_reg <= r_ny_next;
            r_d_reg <= r_d_next;
            r_ok_reg <= r_ok_next;
            r_negx_reg <= wx[39];
            r_negy_reg <= wy[39];
            dv_item_reg[0] <= r_item_reg;
            dv_flags_reg[0] <= dv_flags_next;
            dv_d_reg[0] <= r_d_reg;
            dv_rx_reg[0] <= dv_rx_next[0];
            dv_ry_reg[0] <= dv_ry_next[0];
            dv_qx_reg[0] <= dv_qx_next[0];
            dv_qy_reg[0] <= dv_qy_next[0];
            for (int j = 0; j < DV; j++)
            begin
                dv_item_reg[j + 1] <= dv_item_reg[j];
                dv_flags_reg[j + 1] <= dv_flags_reg[j];
                dv_d_reg[j + 1] <= dv_d_reg[j];
                dv_rx_reg[j + 1] <= dv_rx_next[j + 1];
                dv_ry_reg[j + 1] <= dv_ry_next[j + 1];
                dv_qx_reg[j + 1] <= dv_qx_next[j + 1];
                dv_qy_reg[j + 1] <= dv_qy_next[j + 1];
            end
            dest_x_reg <= dest_x_next;
            dest_y_reg <= dest_y_next;
            dest_pixel_reg <= fin_item.pix;
        end
    end

    assign out_valid = out_vld_reg;
    assign dest_x = dest_x_reg;
    assign dest_y = dest_y_reg;
    assign dest_pixel = dest_pixel_reg;

endmodule

// ===== tb/spherical_bulge_pixel_mapper_tb.sv =====
// Testbench of the spherical bulge pixel mapper: directed and random pixels checked against a predictor.
`timescale 1ns / 100ps

// Keeps the predicted canvas positions and checks each output transfer.
class placement_board;
    typedef struct {
        logic [11:0] x;
        logic [9:0]  y;
        logic        pix;
    } place_t;

    // Register copies.
    bit                 warp_on;
    logic signed [15:0] plane_k;
    logic [14:0]        eye_z;
    logic [12:0]        cols;
    logic [10:0]        rows;
    logic [9:0]         base_y;
    place_t             pending[$];
    int                 fails;

    function new();
        warp_on = 0;
        plane_k = 0;
        eye_z = 15'd8192;
        cols = 13'd4096;
        rows = 11'd1024;
        base_y = 0;
        fails = 0;
    endfunction

    function void set_reg(int idx, logic [15:0] v);
        case (idx)
            sbpm_pkg::CFG_WARP_ENABLE: warp_on = v[0];
            sbpm_pkg::CFG_VIEW_PLANE_K: plane_k = v;
            sbpm_pkg::CFG_EYE_HEIGHT_Z: eye_z = v[14:0];
            sbpm_pkg::CFG_CANVAS_COLS: cols = v[12:0];
            sbpm_pkg::CFG_CANVAS_ROWS: rows = v[10:0];
            sbpm_pkg::CFG_BASELINE_Y: base_y = v[9:0];
            default: ;
        endcase
    endfunction

    function longint floor_root(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 2000000;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function longint round_half_away(longint v, longint d);
        longint a;
        a = v < 0 ? -v : v;
        a = (2 * a + d) / (2 * d);
        return v < 0 ? -a : a;
    endfunction

    function longint clamp_canvas(longint v, longint lim, longint maxv);
        if (lim > maxv)
            lim = maxv;
        if (lim < 1)
            lim = 1;
        if (v < 0)
            return 0;
        if (v > lim - 1)
            return lim - 1;
        return v;
    endfunction

    // Notes an accepted pixel and predicts where it lands.
    function void note_pixel(logic [7:0] col, logic [7:0] row, logic [8:0] w, logic [8:0] h,
                             logic signed [8:0] bl, logic signed [8:0] bt, logic [11:0] pen,
                             logic pix);
        longint gw, gh, px, py, cx, cy, r, dx, dy, rad, hs, num, den, k, z;
        place_t p;
        gw = w > 256 ? 256 : w;
        gh = h > 256 ? 256 : h;
        px = col;
        py = row;
        if (warp_on)
        begin
            k = plane_k;
            z = eye_z;
            cx = gw << 11;
            cy = gh << 11;
            r = (gw > gh ? gw : gh) << 11;
            dx = (longint'(col) << 12) - cx;
            dy = (longint'(row) << 12) - cy;
            rad = r * r - dx * dx - dy * dy;
            hs = rad > 0 ? floor_root(rad) : 0;
            num = r * (z - k);
            den = r * z - hs * 4096;
            if (den > 0)
            begin
                px = round_half_away(cx * den + dx * num, den * 4096);
                py = round_half_away(cy * den + dy * num, den * 4096);
            end
        end
        p.x = 12'(clamp_canvas(px + longint'(bl) + longint'(pen), cols, 4096));
        p.y = 10'(clamp_canvas(py - longint'(bt) + longint'(base_y), rows, 1024));
        p.pix = pix;
        pending.push_back(p);
    endfunction

    function void check_placement(logic [11:0] x, logic [9:0] y, logic pix);
        place_t p;
        if (pending.size() == 0)
        begin
            $error("unexpected output transfer x=%0d y=%0d", x, y);
            fails++;
            return;
        end
        p = pending.pop_front();
        if (x !== p.x)
        begin
            $error("dest_x: expected %0d, actual %0d", p.x, x);
            fails++;
        end
        if (y !== p.y)
        begin
            $error("dest_y: expected %0d, actual %0d", p.y, y);
            fails++;
        end
        if (pix !== p.pix)
        begin
            $error("dest_pixel: expected %0d, actual %0d", p.pix, pix);
            fails++;
        end
    endfunction
endclass

module spherical_bulge_pixel_mapper_tb;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              cfg_write = 0;
    logic [sbpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sbpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [7:0]        src_col = 0;
    logic [7:0]        src_row = 0;
    logic [8:0]        glyph_width = 1;
    logic [8:0]        glyph_height = 1;
    logic signed [8:0] bearing_left = 0;
    logic signed [8:0] bearing_top = 0;
    logic [11:0]       pen_x = 0;
    logic              pixel_on = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [11:0]       dest_x;
    logic [9:0]        dest_y;
    logic              dest_pixel;

    // Idle rates in percent for each side; changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    placement_board board = new();

    spherical_bulge_pixel_mapper i_dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Output side: every rising edge with valid high and stall low is one transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_placement(dest_x, dest_y, dest_pixel);
    end

    // The receiver picks its stall for the next cycle at each falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Writes one register; the pipeline must be empty.
    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 0;
        board.set_reg(idx, v);
        @(negedge clk);
    endtask

    // Sends one pixel, with a random idle gap before it, and waits for its transfer.
    task automatic send_pixel(logic [7:0] col, logic [7:0] row, logic [8:0] w, logic [8:0] h,
                              logic [8:0] bl, logic [8:0] bt, logic [11:0] pen, logic pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        src_col <= col;
        src_row <= row;
        glyph_width <= w;
        glyph_height <= h;
        bearing_left <= bl;
        bearing_top <= bt;
        pen_x <= pen;
        pixel_on <= pix;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pixel(col, row, w, h, bl, bt, pen, pix);
        @(negedge clk);
    endtask

    // Lowers valid and waits until every predicted result has come out.
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    // A random pixel, mostly inside its glyph, of a glyph that is mostly of modest size.
    task automatic random_pixel();
        logic [8:0] w, h;
        logic [7:0] c, r;
        w = ($urandom_range(19) == 0) ? 9'($urandom_range(511, 1)) : 9'($urandom_range(64, 1));
        h = ($urandom_range(19) == 0) ? 9'($urandom_range(511, 1)) : 9'($urandom_range(64, 1));
        if ($urandom_range(9) == 0)
        begin
            c = 8'($urandom);
            r = 8'($urandom);
        end
        else
        begin
            c = 8'($urandom_range((w > 256 ? 256 : w) - 1));
            r = 8'($urandom_range((h > 256 ? 256 : h) - 1));
        end
        send_pixel(c, r, w, h, 9'($urandom), 9'($urandom),
                   ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(200)),
                   1'($urandom));
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Unwarped placement at reset settings, with field extremes.
        send_pixel(0, 0, 1, 1, 0, 0, 0, 0);
        send_pixel(255, 255, 256, 256, 9'sd255, -9'sd128, 4095, 1);
        send_pixel(255, 255, 511, 511, -9'sd128, 9'sd255, 0, 1);
        send_pixel(3, 7, 8, 8, -9'sd1, -9'sd1, 4095, 0);
        drain();

        // Warp on with other defaults and baseline 1023: corners clamp the radicand, centre lifts most.
        write_reg(sbpm_pkg::CFG_WARP_ENABLE, 1);
        write_reg(sbpm_pkg::CFG_BASELINE_Y, 1023);
        send_pixel(0, 0, 16, 16, 0, 0, 100, 1);
        send_pixel(8, 8, 16, 16, 0, 0, 100, 1);
        send_pixel(15, 3, 16, 9, 5, 5, 100, 1);
        send_pixel(200, 200, 16, 16, 0, 0, 100, 1);
        send_pixel(255, 255, 511, 300, 0, 0, 2000, 1);
        send_pixel(0, 0, 0, 0, 0, 0, 10, 1);
        drain();

        // Degenerate eye height and k extremes, with a one-pixel canvas.
        write_reg(sbpm_pkg::CFG_EYE_HEIGHT_Z, 4097);
        write_reg(sbpm_pkg::CFG_VIEW_PLANE_K, 16'h8000);
        write_reg(sbpm_pkg::CFG_CANVAS_COLS, 1);
        write_reg(sbpm_pkg::CFG_CANVAS_ROWS, 1);
        send_pixel(4, 4, 8, 8, 0, 0, 7, 1);
        send_pixel(8, 8, 16, 16, 0, 0, 7, 0);
        drain();
        write_reg(sbpm_pkg::CFG_EYE_HEIGHT_Z, 16'hFFFF);
        write_reg(sbpm_pkg::CFG_VIEW_PLANE_K, 16'h7FFF);
        write_reg(sbpm_pkg::CFG_CANVAS_COLS, 16'hFFFF);
        write_reg(sbpm_pkg::CFG_CANVAS_ROWS, 16'hFFFF);
        write_reg(7, 16'hFFFF);
        send_pixel(2, 13, 32, 20, 3, -9'sd4, 50, 1);
        send_pixel(31, 19, 32, 20, 3, -9'sd4, 50, 1);
        drain();
        write_reg(sbpm_pkg::CFG_EYE_HEIGHT_Z, 4096);
        send_pixel(5, 5, 10, 10, 0, 0, 50, 1);
        drain();

        // Random phases: settings change between blocks, idle rates by phase.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 52 : 0;
            recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 25 : 0;
            for (int blk = 0; blk < 8; blk++)
            begin
                drain();
                write_reg(sbpm_pkg::CFG_WARP_ENABLE, 16'($urandom_range(3) != 0));
                write_reg(sbpm_pkg::CFG_VIEW_PLANE_K, 16'($urandom));
                write_reg(sbpm_pkg::CFG_EYE_HEIGHT_Z,
                          16'($urandom_range(32767, 4097) | ($urandom & 16'h8000)));
                write_reg(sbpm_pkg::CFG_CANVAS_COLS,
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'd4096);
                write_reg(sbpm_pkg::CFG_CANVAS_ROWS,
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'd1024);
                write_reg(sbpm_pkg::CFG_BASELINE_Y, 16'($urandom_range(1023)));
                for (int n = 0; n < 60; n++)
                    random_pixel();
            end
        end

        drain();
        if (board.fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
